### sv/assert_macros.svh
// Assertion macros for the page table engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge while rst_n is high.
`define TLPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold while rst_n is high.
`define TLPT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### sv/tlpt_pkg.sv
// Types and constants shared by the page table engine modules.
`default_nettype none

package tlpt_pkg;

  localparam int ENTRIES = 1024;
  localparam int IDX_W   = 10;

  localparam logic [31:0] FRAME_MASK = 32'hffff_f000;
  localparam logic [11:0] DIR_FLAGS  = 12'h007;

  typedef enum logic [1:0] {
    OP_MAP   = 2'd0,
    OP_UNMAP = 2'd1,
    OP_XLAT  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_UNALIGNED    = 3'd1,
    ST_NO_MEM       = 3'd2,
    ST_EXISTS       = 3'd3,
    ST_ALREADY_FREE = 3'd4,
    ST_NO_DIR       = 3'd5,
    ST_NO_TABLE     = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIR,
    S_ZERO,
    S_TAB,
    S_RESP
  } state_t;

  typedef struct packed {
    logic             en;
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [31:0]      wdata;
  } dir_req_t;

endpackage

`default_nettype wire

### sv/tlpt_dir_mem.sv
// Page directory memory: single port, registered read.
`default_nettype none

module tlpt_dir_mem (
  input  wire                 clk,
  input  tlpt_pkg::dir_req_t  req,
  output logic [31:0]         rdata
);
  import tlpt_pkg::*;

  logic [31:0] mem [ENTRIES];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr] <= req.wdata;
      end else begin
        rdata_r <= mem[req.addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### sv/tlpt_pool_mem.sv
// Second-level table pool memory: single port, registered read.
`default_nettype none

module tlpt_pool_mem #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  wire           clk,
  input  wire           en,
  input  wire           we,
  input  wire  [AW-1:0] addr,
  input  wire  [31:0]   wdata,
  output logic [31:0]   rdata
);
  import tlpt_pkg::*;

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### sv/tlpt_ctrl.sv
// Walk sequencer: directory clear, table walk, table zeroing and result register.
`default_nettype none
`include "assert_macros.svh"

module tlpt_ctrl #(
  parameter int TABLE_POOL_SIZE = 16,
  localparam int PA_W = $clog2(TABLE_POOL_SIZE * tlpt_pkg::ENTRIES)
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire  [1:0]          in_opcode,
  input  wire  [31:0]         in_virt_addr,
  input  wire  [31:0]         in_phys_addr,
  input  wire  [11:0]         in_permissions,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic [2:0]          out_status,
  output logic [31:0]         out_translated_addr,
  output tlpt_pkg::dir_req_t  dir_req,
  input  wire  [31:0]         dir_rdata,
  output logic                pool_en,
  output logic                pool_we,
  output logic [PA_W-1:0]     pool_addr,
  output logic [31:0]         pool_wdata,
  input  wire  [31:0]         pool_rdata
);
  import tlpt_pkg::*;

  localparam int SLOT_W = (TABLE_POOL_SIZE > 1) ? $clog2(TABLE_POOL_SIZE) : 1;
  localparam int TU_W   = $clog2(TABLE_POOL_SIZE + 1);

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    cnt_r, cnt_nxt;
  logic [TU_W-1:0]     tables_used_r, tables_used_nxt;
  opcode_t             op_r, op_nxt;
  logic [31:0]         va_r, va_nxt;
  logic [31:0]         pa_r, pa_nxt;
  logic [11:0]         perm_r, perm_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [31:0]         res_xlat_r, res_xlat_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [31:0]         out_xlat_r, out_xlat_nxt;

  logic                dir_ok;
  logic                map_unaligned;
  logic                te_present;
  logic [31:0]         new_pte;
  logic [IDX_W-1:0]    tab_idx;

  assign tab_idx       = va_r[21:12];
  assign dir_ok        = dir_rdata[0] && (dir_rdata[31:12] < 20'(TABLE_POOL_SIZE));
  assign map_unaligned = (pa_r[11:0] != 12'd0) || (va_r[11:0] != 12'd0);
  assign te_present    = pool_rdata[0];
  assign new_pte       = (pa_r & FRAME_MASK) | {20'd0, perm_r} | 32'd1;

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    tables_used_nxt = tables_used_r;
    op_nxt          = op_r;
    va_nxt          = va_r;
    pa_nxt          = pa_r;
    perm_nxt        = perm_r;
    slot_nxt        = slot_r;
    res_status_nxt  = res_status_r;
    res_xlat_nxt    = res_xlat_r;
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_xlat_nxt    = out_xlat_r;
    in_ready        = 1'b0;
    dir_req         = '0;
    pool_en         = 1'b0;
    pool_we         = 1'b0;
    pool_addr       = PA_W'({slot_r, tab_idx});
    pool_wdata      = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        dir_req.en = 1'b1;
        dir_req.we = 1'b1;
        dir_req.addr = cnt_r;
        cnt_nxt = cnt_r + 1'b1;
        if (&cnt_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt = opcode_t'(in_opcode);
          va_nxt = in_virt_addr;
          pa_nxt = in_phys_addr;
          perm_nxt = in_permissions;
          dir_req.en = 1'b1;
          dir_req.addr = in_virt_addr[31:22];
          state_nxt = S_DIR;
        end
      end
      S_DIR: begin
        state_nxt = S_RESP;
        res_xlat_nxt = '0;
        res_status_nxt = ST_OK;
        case (op_r)
          OP_MAP: begin
            if (map_unaligned) begin
              res_status_nxt = ST_UNALIGNED;
            end else if (dir_ok) begin
              pool_en = 1'b1;
              pool_addr = PA_W'({dir_rdata[12 +: SLOT_W], tab_idx});
              slot_nxt = dir_rdata[12 +: SLOT_W];
              state_nxt = S_TAB;
            end else if (tables_used_r >= TU_W'(TABLE_POOL_SIZE)) begin
              res_status_nxt = ST_NO_MEM;
            end else begin
              dir_req.en = 1'b1;
              dir_req.we = 1'b1;
              dir_req.addr = va_r[31:22];
              dir_req.wdata = {20'(tables_used_r), DIR_FLAGS};
              slot_nxt = SLOT_W'(tables_used_r);
              tables_used_nxt = tables_used_r + 1'b1;
              cnt_nxt = '0;
              state_nxt = S_ZERO;
            end
          end
          OP_UNMAP: begin
            if (va_r[11:0] != 12'd0) begin
              res_status_nxt = ST_UNALIGNED;
            end else if (dir_ok) begin
              pool_en = 1'b1;
              pool_addr = PA_W'({dir_rdata[12 +: SLOT_W], tab_idx});
              slot_nxt = dir_rdata[12 +: SLOT_W];
              state_nxt = S_TAB;
            end else begin
              res_status_nxt = ST_ALREADY_FREE;
            end
          end
          OP_XLAT: begin
            if (dir_ok) begin
              pool_en = 1'b1;
              pool_addr = PA_W'({dir_rdata[12 +: SLOT_W], tab_idx});
              slot_nxt = dir_rdata[12 +: SLOT_W];
              state_nxt = S_TAB;
            end else begin
              res_status_nxt = ST_NO_DIR;
            end
          end
          OP_NONE: begin
            res_status_nxt = ST_OK;
          end
          default: begin
            res_status_nxt = ST_OK;
          end
        endcase
      end
      S_ZERO: begin
        // A fresh table is swept to zero; the mapped entry is written on the way.
        pool_en = 1'b1;
        pool_we = 1'b1;
        pool_addr = PA_W'({slot_r, cnt_r});
        pool_wdata = (cnt_r == tab_idx) ? new_pte : '0;
        cnt_nxt = cnt_r + 1'b1;
        if (&cnt_r) begin
          res_status_nxt = ST_OK;
          state_nxt = S_RESP;
        end
      end
      S_TAB: begin
        state_nxt = S_RESP;
        case (op_r)
          OP_MAP: begin
            if (te_present) begin
              res_status_nxt = ST_EXISTS;
            end else begin
              pool_en = 1'b1;
              pool_we = 1'b1;
              pool_wdata = new_pte;
            end
          end
          OP_UNMAP: begin
            if (te_present) begin
              pool_en = 1'b1;
              pool_we = 1'b1;
            end else begin
              res_status_nxt = ST_ALREADY_FREE;
            end
          end
          OP_XLAT: begin
            if (te_present) begin
              res_xlat_nxt = (pool_rdata & FRAME_MASK) | {20'd0, va_r[11:0]};
            end else begin
              res_status_nxt = ST_NO_TABLE;
            end
          end
          default: begin
            res_status_nxt = ST_OK;
          end
        endcase
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_status_nxt = res_status_r;
          out_xlat_nxt = res_xlat_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
        cnt_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      cnt_r         <= '0;
      tables_used_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      tables_used_r <= tables_used_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    va_r         <= va_nxt;
    pa_r         <= pa_nxt;
    perm_r       <= perm_nxt;
    slot_r       <= slot_nxt;
    res_status_r <= res_status_nxt;
    res_xlat_r   <= res_xlat_nxt;
    out_status_r <= out_status_nxt;
    out_xlat_r   <= out_xlat_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_translated_addr = out_xlat_r;

  `TLPT_ASSERT(a_pool_bound, tables_used_r <= TU_W'(TABLE_POOL_SIZE), "pool count overflow")
  `TLPT_ASSERT(a_alloc_writes_dir, ($past(rst_n) && (tables_used_r != $past(tables_used_r))) |-> $past(dir_req.we && (state_r == S_DIR)), "table taken without directory write")
  `TLPT_ASSERT(a_result_from_resp, $rose(out_valid_r) |-> $past(state_r == S_RESP), "result loaded outside response step")
  `TLPT_NEVER(a_pool_write_state, pool_we && (state_r != S_TAB) && (state_r != S_ZERO), "pool written outside walk")

endmodule

`default_nettype wire

### sv/two_level_page_table_engine_top.sv
// Top level of the two-level page table engine: sequencer plus two memories.
//
//   channel  direction  handshake              word contents
//   in_      input      in_valid / in_ready    opcode, virt_addr, phys_addr, permissions
//   out_     output     out_valid / out_ready  status, translated_addr
//
// A full walk runs these steps in order: accept with the directory read,
// directory decode with the table read, table decode with any write-back,
// result load. A word that the directory step already settles (misaligned,
// no table left, absent directory entry, spare opcode) skips the table step.
// A map that needs a new table instead sweeps all 1024 entries of that table
// in the pool memory to zero, writing the mapped entry on the way. After
// reset all 1024 directory entries are cleared while in_ready stays low. A
// finished word waits in the output register; the next word is accepted
// meanwhile and holds in its result step until the register frees.
`default_nettype none

module two_level_page_table_engine_top #(
  parameter int TABLE_POOL_SIZE = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [1:0]  in_opcode,
  input  wire  [31:0] in_virt_addr,
  input  wire  [31:0] in_phys_addr,
  input  wire  [11:0] in_permissions,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_translated_addr
);
  import tlpt_pkg::*;

  // The pool holds every second-level table back to back, slot number on top.
  localparam int POOL_DEPTH = TABLE_POOL_SIZE * ENTRIES;
  localparam int PA_W       = $clog2(POOL_DEPTH);

  dir_req_t          dir_req;
  logic [31:0]       dir_rdata;
  logic              pool_en;
  logic              pool_we;
  logic [PA_W-1:0]   pool_addr;
  logic [31:0]       pool_wdata;
  logic [31:0]       pool_rdata;

  tlpt_ctrl #(
    .TABLE_POOL_SIZE(TABLE_POOL_SIZE)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_virt_addr       (in_virt_addr),
    .in_phys_addr       (in_phys_addr),
    .in_permissions     (in_permissions),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_translated_addr(out_translated_addr),
    .dir_req            (dir_req),
    .dir_rdata          (dir_rdata),
    .pool_en            (pool_en),
    .pool_we            (pool_we),
    .pool_addr          (pool_addr),
    .pool_wdata         (pool_wdata),
    .pool_rdata         (pool_rdata)
  );

  // Directory entries carry the pool slot number in bits 31..12.
  tlpt_dir_mem u_dir_mem (
    .clk  (clk),
    .req  (dir_req),
    .rdata(dir_rdata)
  );

  tlpt_pool_mem #(
    .DEPTH(POOL_DEPTH),
    .AW   (PA_W)
  ) u_pool_mem (
    .clk  (clk),
    .en   (pool_en),
    .we   (pool_we),
    .addr (pool_addr),
    .wdata(pool_wdata),
    .rdata(pool_rdata)
  );

endmodule

`default_nettype wire
